>>> rtl/e2r_pkg.sv
// Shared types and constants for the Euler angle to rotation matrix pipeline.
// No dependencies; the trig, term, rotation and top-level files import this package.
package e2r_pkg;

	localparam int TERMS = 9;

	localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic [31:0]        ONE_Q30     = 32'd1073741824;

	typedef enum logic [1:0] {
		AX_X    = 2'd0,
		AX_Y    = 2'd1,
		AX_Z    = 2'd2,
		AX_NONE = 2'd3
	} axis_t;

	// Running state of one angle's sine and cosine series.
	typedef struct packed {
		logic [31:0]        t_s;
		logic [31:0]        t_c;
		logic signed [32:0] s_sum;
		logic signed [32:0] c_sum;
		logic [31:0]        x2;
		logic               neg;
		logic               flip;
	} trig_t;

	// Item state in the rotation chain: Q30 sines, cosines and the matrix so far.
	typedef struct packed {
		axis_t [2:0]       slot;
		logic [2:0][31:0]  sn;
		logic [2:0][31:0]  cs;
		logic [8:0][31:0]  m;
	} rot_t;

	function automatic int sin_div(int k);
		return (2 * k) * (2 * k + 1);
	endfunction

	function automatic int cos_div(int k);
		return (2 * k - 1) * (2 * k);
	endfunction

endpackage

>>> rtl/e2r_in_if.sv
// Input channel: three angles and the axis order, valid/ready handshake.
// Depends on nothing.
interface e2r_in_if #(parameter int ANGLE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] x_angle;
	logic signed [ANGLE_WIDTH-1:0] y_angle;
	logic signed [ANGLE_WIDTH-1:0] z_angle;
	logic                          use_default;
	logic [1:0]                    axis_first;
	logic [1:0]                    axis_second;
	logic [1:0]                    axis_third;

	modport source (output valid, x_angle, y_angle, z_angle, use_default,
		axis_first, axis_second, axis_third, input ready);
	modport sink (input valid, x_angle, y_angle, z_angle, use_default,
		axis_first, axis_second, axis_third, output ready);
endinterface

>>> rtl/e2r_out_if.sv
// Output channel: nine matrix elements, valid/ready handshake.
// Depends on nothing.
interface e2r_out_if #(parameter int ELEMENT_WIDTH = 16);
	logic                            valid;
	logic                            ready;
	logic signed [ELEMENT_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

>>> rtl/e2r_trig_front.sv
// Head cell of one trig lane: range reduction to [-pi/2, pi/2] and the square.
// Depends on e2r_pkg.
module e2r_trig_front #(
	parameter int AW = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] angle,
	output e2r_pkg::trig_t       q
);
	import e2r_pkg::*;

	logic signed [34:0] th, red, mag;
	logic               flip, neg;
	logic [30:0]        x_s1;
	logic               neg_s1, flip_s1;
	logic [62:0]        sq;

	assign th = 35'(angle) <<< (33 - AW);

	always_comb begin
		red  = th;
		flip = 1'b0;
		if (th > HALF_PI_Q30) begin
			red  = th - PI_Q30;
			flip = 1'b1;
		end else if (th < -HALF_PI_Q30) begin
			red  = th + PI_Q30;
			flip = 1'b1;
		end
		neg = red < 0;
		mag = neg ? -red : red;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= mag[30:0];
			neg_s1  <= neg;
			flip_s1 <= flip;
		end
	end

	assign sq = 63'(x_s1) * 63'(x_s1) + (63'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			q.t_s   <= {1'b0, x_s1};
			q.t_c   <= ONE_Q30;
			q.s_sum <= $signed({2'b00, x_s1});
			q.c_sum <= $signed({1'b0, ONE_Q30});
			q.x2    <= sq[61:30];
			q.neg   <= neg_s1;
			q.flip  <= flip_s1;
		end
	end

endmodule

>>> rtl/e2r_term_cell.sv
// One series term for sine and cosine: multiply by x^2, divide by a constant
// through a reciprocal with one correction step, and accumulate. Three stages.
// Depends on e2r_pkg.
module e2r_term_cell #(
	parameter int K = 1
) (
	input  logic           clk,
	input  logic           en,
	input  e2r_pkg::trig_t d,
	output e2r_pkg::trig_t q
);
	import e2r_pkg::*;

	localparam int          DS  = sin_div(K);
	localparam int          DC  = cos_div(K);
	localparam logic [31:0] MS  = 32'(64'd4294967296 / DS);
	localparam logic [31:0] MC  = 32'(64'd4294967296 / DC);
	localparam logic [8:0]  DSW = 9'(DS);
	localparam logic [8:0]  DCW = 9'(DC);
	localparam bit          SUB = (K % 2) == 1;

	logic [63:0] ps_full, pc_full, qs_full, qc_full;
	logic [40:0] qds, qdc;
	logic [31:0] rs, rc, ts, tc;
	trig_t       a_s1, a_s2;
	logic [31:0] ps_s1, pc_s1, ps_s2, pc_s2, qs_s2, qc_s2;

	assign ps_full = d.t_s * d.x2;
	assign pc_full = d.t_c * d.x2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= d;
			ps_s1 <= ps_full[61:30];
			pc_s1 <= pc_full[61:30];
		end
	end

	// The reciprocal estimate is the true quotient or one below it.
	assign qs_full = ps_s1 * MS;
	assign qc_full = pc_s1 * MC;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= a_s1;
			ps_s2 <= ps_s1;
			pc_s2 <= pc_s1;
			qs_s2 <= qs_full[63:32];
			qc_s2 <= qc_full[63:32];
		end
	end

	assign qds = qs_s2 * DSW;
	assign qdc = qc_s2 * DCW;
	assign rs  = ps_s2 - qds[31:0];
	assign rc  = pc_s2 - qdc[31:0];
	assign ts  = (rs >= 32'(DSW)) ? qs_s2 + 32'd1 : qs_s2;
	assign tc  = (rc >= 32'(DCW)) ? qc_s2 + 32'd1 : qc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			q.t_s   <= ts;
			q.t_c   <= tc;
			q.s_sum <= SUB ? a_s2.s_sum - $signed({1'b0, ts})
				: a_s2.s_sum + $signed({1'b0, ts});
			q.c_sum <= SUB ? a_s2.c_sum - $signed({1'b0, tc})
				: a_s2.c_sum + $signed({1'b0, tc});
			q.x2    <= a_s2.x2;
			q.neg   <= a_s2.neg;
			q.flip  <= a_s2.flip;
		end
	end

endmodule

>>> rtl/e2r_rot_cell.sv
// One slot of the axis order: left-multiplies the running matrix by the
// elementary rotation for that slot. Products in one stage, sums and rounding
// in the next. Depends on e2r_pkg.
module e2r_rot_cell #(
	parameter int SLOT = 0
) (
	input  logic          clk,
	input  logic          en,
	input  e2r_pkg::rot_t d,
	output e2r_pkg::rot_t q
);
	import e2r_pkg::*;

	axis_t              ax, ax_s1;
	logic signed [31:0] c, s;
	logic               negs, negs_s1;
	logic [2:0][31:0]   rowp, rowq;
	rot_t               a_s1;
	logic signed [63:0] cp_s1 [3];
	logic signed [63:0] sq_s1 [3];
	logic signed [63:0] sp_s1 [3];
	logic signed [63:0] cq_s1 [3];
	logic signed [64:0] sum_p, sum_q;
	logic signed [64:0] rnd_p, rnd_q;
	logic [2:0][31:0]   np, nq;
	rot_t               nxt;

	// Rows p and q are the two rows the rotation mixes; negs flips the sign
	// of the sine terms for the y axis.
	always_comb begin
		ax = d.slot[SLOT];
		unique case (ax)
			AX_X: begin
				c = $signed(d.cs[0]); s = $signed(d.sn[0]); negs = 1'b0;
				rowp = {d.m[5], d.m[4], d.m[3]};
				rowq = {d.m[8], d.m[7], d.m[6]};
			end
			AX_Y: begin
				c = $signed(d.cs[1]); s = $signed(d.sn[1]); negs = 1'b1;
				rowp = {d.m[2], d.m[1], d.m[0]};
				rowq = {d.m[8], d.m[7], d.m[6]};
			end
			AX_Z: begin
				c = $signed(d.cs[2]); s = $signed(d.sn[2]); negs = 1'b0;
				rowp = {d.m[2], d.m[1], d.m[0]};
				rowq = {d.m[5], d.m[4], d.m[3]};
			end
			default: begin
				c = '0; s = '0; negs = 1'b0;
				rowp = '0;
				rowq = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= d;
			ax_s1   <= ax;
			negs_s1 <= negs;
			for (int j = 0; j < 3; j++) begin
				cp_s1[j] <= c * $signed(rowp[j]);
				sq_s1[j] <= s * $signed(rowq[j]);
				sp_s1[j] <= s * $signed(rowp[j]);
				cq_s1[j] <= c * $signed(rowq[j]);
			end
		end
	end

	always_comb begin
		sum_p = '0;
		sum_q = '0;
		rnd_p = '0;
		rnd_q = '0;
		for (int j = 0; j < 3; j++) begin
			sum_p = negs_s1 ? 65'(cp_s1[j]) - 65'(sq_s1[j]) : 65'(cp_s1[j]) + 65'(sq_s1[j]);
			sum_q = negs_s1 ? 65'(cq_s1[j]) + 65'(sp_s1[j]) : 65'(cq_s1[j]) - 65'(sp_s1[j]);
			rnd_p = (sum_p + 65'sd536870912) >>> 30;
			rnd_q = (sum_q + 65'sd536870912) >>> 30;
			np[j] = rnd_p[31:0];
			nq[j] = rnd_q[31:0];
		end
		nxt = a_s1;
		unique case (ax_s1)
			AX_X: begin
				nxt.m[5:3] = np;
				nxt.m[8:6] = nq;
			end
			AX_Y: begin
				nxt.m[2:0] = np;
				nxt.m[8:6] = nq;
			end
			AX_Z: begin
				nxt.m[2:0] = np;
				nxt.m[5:3] = nq;
			end
			default: begin
				nxt = a_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

>>> rtl/euler_to_rotation_matrix_core.sv
// Top level: three trig lanes of series cells, then three rotation cells.
// Depends on e2r_pkg, e2r_in_if, e2r_out_if, e2r_trig_front, e2r_term_cell, e2r_rot_cell.
//
//   channel  | dir | contents
//   ---------+-----+------------------------------------------------
//   angles   | in  | x/y/z angles, use_default, three axis slots
//   matrix   | out | m00..m22, rounded and saturated
//
// One item enters per cycle while the pipeline is not stalled. From acceptance to a
// valid output an item passes 2 front stages, 9 three-stage term cells per lane, one sign
// stage and 3 two-stage rotation cells, plus the output register.
// Reset clears only the valid line and the output valid.
// The pipeline moves whenever the output register is free or its last stage is
// empty, so items keep entering while a finished result waits, until one reaches the last stage.
module euler_to_rotation_matrix_core #(
	parameter int ANGLE_WIDTH   = 16,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	e2r_in_if.sink    angles,
	e2r_out_if.source matrix
);
	import e2r_pkg::*;

	localparam int TRIG_LAT = 2 + 3 * TERMS;
	localparam int N        = TRIG_LAT + 1 + 6;
	localparam int SH_E     = 32 - ELEMENT_WIDTH;
	localparam logic signed [32:0] HALF_E = 33'((64'd1 << SH_E) >> 1);
	localparam logic signed [32:0] HI_E   = 33'((64'sd1 <<< (ELEMENT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [32:0] LO_E   = -HI_E - 33'sd1;

	logic                          ld, adv;
	logic [N-1:0]                  v_q;
	logic                          out_v_q;
	axis_t [2:0]                   slot_in;
	axis_t [2:0]                   slot_q [TRIG_LAT];
	logic signed [ANGLE_WIDTH-1:0] ang [3];
	trig_t                         lane [3][TERMS+1];
	rot_t                          rot [4];
	logic [ELEMENT_WIDTH-1:0]      el_q [9];

	function automatic logic [ELEMENT_WIDTH-1:0] to_el(logic [31:0] v);
		logic signed [32:0] t;
		logic signed [32:0] r;
		t = 33'($signed(v)) + HALF_E;
		r = t >>> SH_E;
		if (r > HI_E) begin
			r = HI_E;
		end else if (r < LO_E) begin
			r = LO_E;
		end
		return r[ELEMENT_WIDTH-1:0];
	endfunction

	assign ld           = !out_v_q || matrix.ready;
	assign adv          = ld || !v_q[N-1];
	assign angles.ready = adv;

	assign ang[0] = angles.x_angle;
	assign ang[1] = angles.y_angle;
	assign ang[2] = angles.z_angle;

	always_comb begin
		if (angles.use_default) begin
			slot_in = {AX_Y, AX_X, AX_Z};
		end else begin
			slot_in = {axis_t'(angles.axis_third), axis_t'(angles.axis_second),
				axis_t'(angles.axis_first)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				v_q <= {v_q[N-2:0], angles.valid};
			end
			if (ld) begin
				out_v_q <= v_q[N-1];
			end
		end
	end

	// Axis order rides beside the trig lanes until the sign stage.
	always_ff @(posedge clk) begin
		if (adv) begin
			slot_q[0] <= slot_in;
			for (int i = 1; i < TRIG_LAT; i++) begin
				slot_q[i] <= slot_q[i-1];
			end
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_lane
		e2r_trig_front #(.AW(ANGLE_WIDTH)) u_front (
			.clk  (clk),
			.en   (adv),
			.angle(ang[a]),
			.q    (lane[a][0])
		);
		for (genvar k = 1; k <= TERMS; k++) begin : g_term
			e2r_term_cell #(.K(k)) u_term (
				.clk(clk),
				.en (adv),
				.d  (lane[a][k-1]),
				.q  (lane[a][k])
			);
		end
	end

	// Sign stage: undo the reduction and start from identity.
	always_ff @(posedge clk) begin
		if (adv) begin
			rot[0].slot <= slot_q[TRIG_LAT-1];
			for (int a = 0; a < 3; a++) begin
				rot[0].sn[a] <= (lane[a][TERMS].neg ^ lane[a][TERMS].flip)
					? 32'(-lane[a][TERMS].s_sum) : 32'(lane[a][TERMS].s_sum);
				rot[0].cs[a] <= lane[a][TERMS].flip
					? 32'(-lane[a][TERMS].c_sum) : 32'(lane[a][TERMS].c_sum);
			end
			for (int i = 0; i < 9; i++) begin
				rot[0].m[i] <= (i % 4 == 0) ? ONE_Q30 : 32'd0;
			end
		end
	end

	for (genvar s = 0; s < 3; s++) begin : g_rot
		e2r_rot_cell #(.SLOT(s)) u_rot (
			.clk(clk),
			.en (adv),
			.d  (rot[s]),
			.q  (rot[s+1])
		);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			for (int i = 0; i < 9; i++) begin
				el_q[i] <= to_el(rot[3].m[i]);
			end
		end
	end

	assign matrix.valid = out_v_q;
	assign matrix.m00   = el_q[0];
	assign matrix.m01   = el_q[1];
	assign matrix.m02   = el_q[2];
	assign matrix.m10   = el_q[3];
	assign matrix.m11   = el_q[4];
	assign matrix.m12   = el_q[5];
	assign matrix.m20   = el_q[6];
	assign matrix.m21   = el_q[7];
	assign matrix.m22   = el_q[8];

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && angles.ready |=> v_q[0])
		else $error("accepted item did not enter the pipeline");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!angles.ready |-> matrix.valid && !matrix.ready && v_q[N-1])
		else $error("input stalled without a full, blocked output");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!angles.ready |=> $stable(v_q))
		else $error("pipeline moved during a stall");

endmodule
